### sv/big_digit_lcd_renderer_defines.svh
// Assertion macros shared by the big-digit LCD renderer RTL.
`ifndef BIG_DIGIT_LCD_RENDERER_DEFINES_SVH
`define BIG_DIGIT_LCD_RENDERER_DEFINES_SVH

// Clocked assertion that is ignored while reset is asserted.
`define BDLR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BDLR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/bdlr_pkg.sv
// Shared types, constants and tables for the big-digit LCD renderer.
package bdlr_pkg;

  localparam int unsigned VALUE_W         = 7;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned DIGITS          = 6;
  localparam int unsigned CELLS_PER_DIGIT = 6;
  localparam int unsigned CELLS_PER_COLON = 3;
  localparam int unsigned FONT_DIGITS     = 10;
  localparam int unsigned PAIRS_PER_FRAME = 42;
  localparam int unsigned PAIR_W          = $clog2(PAIRS_PER_FRAME);
  localparam int unsigned CELL_W          = $clog2(CELLS_PER_DIGIT);
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX  = VALUE_W'(99);
  localparam logic [BYTE_W-1:0]  SPACE_CODE = 8'h20;
  localparam logic [BYTE_W-1:0]  LAST_ADDR  = 8'hE5;

  // Which group of the frame a pair belongs to.
  typedef enum logic [2:0] {
    SLOT_HOUR_TENS,
    SLOT_HOUR_ONES,
    SLOT_MIN_TENS,
    SLOT_MIN_ONES,
    SLOT_SEC_TENS,
    SLOT_SEC_ONES,
    SLOT_COLON_HM,
    SLOT_COLON_MS
  } slot_e;

  // One classified frame: blank flag and the six decimal digits.
  typedef struct packed {
    logic                            blank;
    logic [DIGITS-1:0][DIGIT_W-1:0]  digits;
  } frame_t;

  localparam logic [BYTE_W-1:0] FONT_ROM [FONT_DIGITS][CELLS_PER_DIGIT] = '{
    '{8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04},
    '{8'h05, 8'h06, 8'h20, 8'h01, 8'h05, 8'h03},
    '{8'h00, 8'h00, 8'h00, 8'h04, 8'h03, 8'h00},
    '{8'h00, 8'h00, 8'h05, 8'h04, 8'h00, 8'h04},
    '{8'h06, 8'h05, 8'h03, 8'h04, 8'h20, 8'h02},
    '{8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h04},
    '{8'h00, 8'h00, 8'h03, 8'h00, 8'h03, 8'h04},
    '{8'h00, 8'h00, 8'h20, 8'h02, 8'h20, 8'h02},
    '{8'h00, 8'h00, 8'h03, 8'h04, 8'h03, 8'h04},
    '{8'h00, 8'h00, 8'h03, 8'h04, 8'h20, 8'h02}
  };

  localparam logic [BYTE_W-1:0] COLON_GLYPHS [CELLS_PER_COLON] = '{8'h20, 8'h07, 8'h07};

  // Cursor address of every pair, in output order.
  localparam logic [BYTE_W-1:0] PAIR_ADDR [PAIRS_PER_FRAME] = '{
    8'hC1, 8'hC2, 8'h95, 8'h96, 8'hD5, 8'hD6,
    8'hC4, 8'hC5, 8'h98, 8'h99, 8'hD8, 8'hD9,
    8'hC6, 8'h9A, 8'hDA,
    8'hC7, 8'hC8, 8'h9B, 8'h9C, 8'hDB, 8'hDC,
    8'hCA, 8'hCB, 8'h9E, 8'h9F, 8'hDE, 8'hDF,
    8'hCC, 8'hA0, 8'hE0,
    8'hCD, 8'hCE, 8'hA1, 8'hA2, 8'hE1, 8'hE2,
    8'hD0, 8'hD1, 8'hA4, 8'hA5, 8'hE4, 8'hE5
  };

  localparam slot_e PAIR_SLOT [PAIRS_PER_FRAME] = '{
    SLOT_HOUR_TENS, SLOT_HOUR_TENS, SLOT_HOUR_TENS,
    SLOT_HOUR_TENS, SLOT_HOUR_TENS, SLOT_HOUR_TENS,
    SLOT_HOUR_ONES, SLOT_HOUR_ONES, SLOT_HOUR_ONES,
    SLOT_HOUR_ONES, SLOT_HOUR_ONES, SLOT_HOUR_ONES,
    SLOT_COLON_HM,  SLOT_COLON_HM,  SLOT_COLON_HM,
    SLOT_MIN_TENS,  SLOT_MIN_TENS,  SLOT_MIN_TENS,
    SLOT_MIN_TENS,  SLOT_MIN_TENS,  SLOT_MIN_TENS,
    SLOT_MIN_ONES,  SLOT_MIN_ONES,  SLOT_MIN_ONES,
    SLOT_MIN_ONES,  SLOT_MIN_ONES,  SLOT_MIN_ONES,
    SLOT_COLON_MS,  SLOT_COLON_MS,  SLOT_COLON_MS,
    SLOT_SEC_TENS,  SLOT_SEC_TENS,  SLOT_SEC_TENS,
    SLOT_SEC_TENS,  SLOT_SEC_TENS,  SLOT_SEC_TENS,
    SLOT_SEC_ONES,  SLOT_SEC_ONES,  SLOT_SEC_ONES,
    SLOT_SEC_ONES,  SLOT_SEC_ONES,  SLOT_SEC_ONES
  };

  localparam logic [CELL_W-1:0] PAIR_CELL [PAIRS_PER_FRAME] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
  };

endpackage

### sv/bdlr_if.sv
// Valid/ready channel interfaces for frame requests and display pairs.
interface bdlr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          blank_hours;
  logic [bdlr_pkg::VALUE_W-1:0]  hours;
  logic [bdlr_pkg::VALUE_W-1:0]  minutes;
  logic [bdlr_pkg::VALUE_W-1:0]  seconds;

  modport source (output valid, blank_hours, hours, minutes, seconds, input ready);
  modport sink   (input valid, blank_hours, hours, minutes, seconds, output ready);
endinterface

interface bdlr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bdlr_pkg::BYTE_W-1:0]  cursor_address;
  logic [bdlr_pkg::BYTE_W-1:0]  glyph_code;
  logic                         last_write;

  modport source (output valid, cursor_address, glyph_code, last_write, input ready);
  modport sink   (input valid, cursor_address, glyph_code, last_write, output ready);
endinterface

### sv/big_digit_lcd_renderer.sv
// Top level of the big-digit LCD renderer: front end, frame queue and pair sequencer.
// A frame is first written into the queue; its first pair is then loaded into the output register.
// The back-end pair counter walks the 42 pairs of a frame, one pair per cycle while the output is not stalled.
// A frame may be accepted while the previous one is still being drawn (queue of QueueDepth).
// Reset (rst_ni low, asynchronous) empties the queue and the output register; no tables
// need a fill pass.
`include "big_digit_lcd_renderer_defines.svh"

module big_digit_lcd_renderer #(
  parameter int unsigned QueueDepth = bdlr_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdlr_in_if.sink     in_i,
  bdlr_out_if.source  out_o
);

  // The front end is purely combinational: it clamps hours, minutes and seconds to 99,
  // splits each into tens and ones digits and hands one classified frame to the queue.
  // The input is ready whenever the queue has a free entry.
  logic              push_valid, push_ready;
  bdlr_pkg::frame_t  push_frame;

  // The back end reads the head of the queue and emits the 42 pairs of that frame in
  // fixed order. The head entry is popped in the cycle that its final pair is loaded into
  // the output register, so a queued frame follows with no idle cycle in between.
  logic              pop_valid, pop_ready;
  bdlr_pkg::frame_t  pop_frame;

  bdlr_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_frame_o (push_frame)
  );

  bdlr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_frame_i (push_frame),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_frame_o  (pop_frame)
  );

  // The output register in the back end holds a stalled pair while the queue keeps taking
  // new frames until it is full; the sink's ready still feeds the pair counter directly.
  bdlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_frame_i (pop_frame),
    .out_o       (out_o)
  );

  // A full queue is never empty.
  `BDLR_ASSERT_ALWAYS(a_full_not_empty, (!push_ready |-> pop_valid), "queue full but empty")

  // A frame accepted into an empty queue shows up at the queue head in the next cycle.
  `BDLR_ASSERT(a_push_lands, (in_i.valid && in_i.ready && !pop_valid |=> pop_valid), "lost frame")

  // The closing pair of a frame always sits at the last cell of the seconds ones digit.
  `BDLR_ASSERT(a_last_addr, (out_o.valid && out_o.last_write |-> out_o.cursor_address == bdlr_pkg::LAST_ADDR), "bad last pair")

  // With nothing queued, taking the closing pair leaves the output empty.
  `BDLR_ASSERT(a_drain, (out_o.valid && out_o.ready && out_o.last_write && !pop_valid |=> !out_o.valid), "extra pair")

endmodule

### sv/bdlr_front.sv
// Front end: accepts frame requests, clamps values and splits them into digits.
module bdlr_front (
  bdlr_in_if.sink             in_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output bdlr_pkg::frame_t    push_frame_o
);

  localparam int unsigned PROD_W = bdlr_pkg::VALUE_W + 8;
  localparam int unsigned SHIFT  = 11;

  logic [bdlr_pkg::VALUE_W-1:0] clamped [3];
  logic [bdlr_pkg::DIGIT_W-1:0] tens    [3];
  logic [bdlr_pkg::DIGIT_W-1:0] ones    [3];
  logic [PROD_W-1:0]            prod    [3];
  logic [bdlr_pkg::VALUE_W-1:0] tens_x10[3];

  assign clamped[0] = (in_i.hours   > bdlr_pkg::VALUE_MAX) ? bdlr_pkg::VALUE_MAX : in_i.hours;
  assign clamped[1] = (in_i.minutes > bdlr_pkg::VALUE_MAX) ? bdlr_pkg::VALUE_MAX : in_i.minutes;
  assign clamped[2] = (in_i.seconds > bdlr_pkg::VALUE_MAX) ? bdlr_pkg::VALUE_MAX : in_i.seconds;

  // Tens digit by reciprocal multiply: (v * 205) >> 11 is exact for v up to 99.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]     = PROD_W'(clamped[i]) * PROD_W'(205);
      tens[i]     = bdlr_pkg::DIGIT_W'(prod[i] >> SHIFT);
      tens_x10[i] = bdlr_pkg::VALUE_W'({tens[i], 3'b000}) + bdlr_pkg::VALUE_W'({tens[i], 1'b0});
      ones[i]     = bdlr_pkg::DIGIT_W'(clamped[i] - tens_x10[i]);
    end
  end

  always_comb begin
    push_frame_o.blank     = in_i.blank_hours;
    push_frame_o.digits[0] = tens[0];
    push_frame_o.digits[1] = ones[0];
    push_frame_o.digits[2] = tens[1];
    push_frame_o.digits[3] = ones[1];
    push_frame_o.digits[4] = tens[2];
    push_frame_o.digits[5] = ones[2];
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

### sv/bdlr_queue.sv
// Short register queue of classified frames between front and back end.
module bdlr_queue #(
  parameter int unsigned Depth = bdlr_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  bdlr_pkg::frame_t  push_frame_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output bdlr_pkg::frame_t  pop_frame_o
);

  localparam int unsigned PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CNT_W = $clog2(Depth + 1);

  bdlr_pkg::frame_t  entries_q [Depth];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_frame_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_frame_i;
    end
  end

endmodule

### sv/bdlr_back.sv
// Back end: walks the 42 pairs of a frame and drives the registered output.
module bdlr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  bdlr_pkg::frame_t  pop_frame_i,
  bdlr_out_if.source        out_o
);

  logic [bdlr_pkg::PAIR_W-1:0]  idx_q, idx_d;
  logic                         valid_q, valid_d;
  logic [bdlr_pkg::BYTE_W-1:0]  addr_q, glyph_q;
  logic                         last_q;

  bdlr_pkg::slot_e              slot;
  logic [bdlr_pkg::CELL_W-1:0]  cell_idx;
  logic [bdlr_pkg::DIGIT_W-1:0] digit;
  logic [bdlr_pkg::BYTE_W-1:0]  glyph;
  logic                         is_last;
  logic                         advance;

  assign slot     = bdlr_pkg::PAIR_SLOT[idx_q];
  assign cell_idx = bdlr_pkg::PAIR_CELL[idx_q];
  assign is_last  = (idx_q == bdlr_pkg::PAIR_W'(bdlr_pkg::PAIRS_PER_FRAME - 1));
  assign advance  = pop_valid_i && (!valid_q || out_o.ready);

  // The queue entry is released once its final pair moves into the output register.
  assign pop_ready_o = advance && is_last;

  always_comb begin
    digit = '0;
    glyph = '0;
    unique case (slot)
      bdlr_pkg::SLOT_HOUR_TENS: digit = pop_frame_i.digits[0];
      bdlr_pkg::SLOT_HOUR_ONES: digit = pop_frame_i.digits[1];
      bdlr_pkg::SLOT_MIN_TENS:  digit = pop_frame_i.digits[2];
      bdlr_pkg::SLOT_MIN_ONES:  digit = pop_frame_i.digits[3];
      bdlr_pkg::SLOT_SEC_TENS:  digit = pop_frame_i.digits[4];
      bdlr_pkg::SLOT_SEC_ONES:  digit = pop_frame_i.digits[5];
      bdlr_pkg::SLOT_COLON_HM,
      bdlr_pkg::SLOT_COLON_MS:  digit = '0;
      default:                  digit = '0;
    endcase

    if (slot == bdlr_pkg::SLOT_COLON_HM || slot == bdlr_pkg::SLOT_COLON_MS) begin
      glyph = bdlr_pkg::COLON_GLYPHS[cell_idx[1:0]];
    end else begin
      glyph = bdlr_pkg::FONT_ROM[digit][cell_idx];
    end

    // Stopwatch view hides the hour digits and the first colon.
    if (pop_frame_i.blank && (slot == bdlr_pkg::SLOT_HOUR_TENS ||
        slot == bdlr_pkg::SLOT_HOUR_ONES || slot == bdlr_pkg::SLOT_COLON_HM)) begin
      glyph = bdlr_pkg::SPACE_CODE;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (advance) begin
      idx_d   = is_last ? '0 : idx_q + 1'b1;
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      addr_q  <= bdlr_pkg::PAIR_ADDR[idx_q];
      glyph_q <= glyph;
      last_q  <= is_last;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.cursor_address = addr_q;
  assign out_o.glyph_code     = glyph_q;
  assign out_o.last_write     = last_q;

endmodule

### dv/big_digit_lcd_renderer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench: drives clock frames into the big-digit LCD renderer and checks pairs.
module big_digit_lcd_renderer_test;

  // Number of random frames after the directed ones.
  localparam int unsigned RANDOM_FRAMES = 330;
  // Length of the long output hold-off that fills the frame queue.
  localparam int unsigned HOLD_CYCLES   = 400;
  // Hard stop for the whole run, in nanoseconds.
  localparam int unsigned RUN_LIMIT_NS  = 2_000_000;

  // One clock frame as offered on the input channel.
  typedef struct packed {
    logic                         blank_hours;
    logic [bdlr_pkg::VALUE_W-1:0] hours;
    logic [bdlr_pkg::VALUE_W-1:0] minutes;
    logic [bdlr_pkg::VALUE_W-1:0] seconds;
  } clock_face_t;

  // One (cursor address, glyph code) pair as seen on the output channel.
  typedef struct packed {
    logic [bdlr_pkg::BYTE_W-1:0] cursor_address;
    logic [bdlr_pkg::BYTE_W-1:0] glyph_code;
    logic                        last_write;
  } lcd_pair_t;

  // The scoreboard renders each accepted frame into the 42 pairs the display
  // should receive and compares every delivered pair with the oldest of them.
  class frame_scoreboard;
    lcd_pair_t   expected_pairs[$];
    int unsigned frames_noted;
    int unsigned pairs_checked;
    int unsigned mismatches;

    // Big-digit font: six glyph codes per decimal digit, first cell in the top byte.
    function logic [47:0] font_row(int unsigned digit);
      case (digit)
        0:       return 48'h00_00_01_02_03_04;
        1:       return 48'h05_06_20_01_05_03;
        2:       return 48'h00_00_00_04_03_00;
        3:       return 48'h00_00_05_04_00_04;
        4:       return 48'h06_05_03_04_20_02;
        5:       return 48'h00_00_03_00_00_04;
        6:       return 48'h00_00_03_00_03_04;
        7:       return 48'h00_00_20_02_20_02;
        8:       return 48'h00_00_03_04_03_04;
        default: return 48'h00_00_03_04_20_02;
      endcase
    endfunction

    // Screen cells of each group; a colon uses only its top three bytes.
    function logic [47:0] cell_row(bdlr_pkg::slot_e slot);
      case (slot)
        bdlr_pkg::SLOT_HOUR_TENS: return 48'hC1_C2_95_96_D5_D6;
        bdlr_pkg::SLOT_HOUR_ONES: return 48'hC4_C5_98_99_D8_D9;
        bdlr_pkg::SLOT_COLON_HM:  return 48'hC6_9A_DA_00_00_00;
        bdlr_pkg::SLOT_MIN_TENS:  return 48'hC7_C8_9B_9C_DB_DC;
        bdlr_pkg::SLOT_MIN_ONES:  return 48'hCA_CB_9E_9F_DE_DF;
        bdlr_pkg::SLOT_COLON_MS:  return 48'hCC_A0_E0_00_00_00;
        bdlr_pkg::SLOT_SEC_TENS:  return 48'hCD_CE_A1_A2_E1_E2;
        default:                  return 48'hD0_D1_A4_A5_E4_E5;
      endcase
    endfunction

    // Values above 99 are drawn as 99.
    function int unsigned to_decimal(logic [bdlr_pkg::VALUE_W-1:0] value);
      return (value > 99) ? 99 : int'(value);
    endfunction

    function void add_group(bdlr_pkg::slot_e slot, int unsigned digit, bit blank);
      logic [47:0] cells;
      logic [47:0] glyphs;
      int unsigned count;
      lcd_pair_t   pair;
      cells = cell_row(slot);
      if (slot == bdlr_pkg::SLOT_COLON_HM || slot == bdlr_pkg::SLOT_COLON_MS) begin
        // A colon is a blank top cell and two dot glyphs below it.
        count  = 3;
        glyphs = 48'h20_07_07_00_00_00;
      end else begin
        count  = 6;
        glyphs = font_row(digit);
      end
      for (int unsigned i = 0; i < count; i++) begin
        pair.cursor_address = cells[47 - 8 * i -: 8];
        pair.glyph_code     = blank ? bdlr_pkg::SPACE_CODE : glyphs[47 - 8 * i -: 8];
        pair.last_write     = 1'b0;
        expected_pairs.push_back(pair);
      end
    endfunction

    // Called once per accepted frame.
    function void note_frame(clock_face_t face);
      int unsigned hh;
      int unsigned mm;
      int unsigned ss;
      hh = to_decimal(face.hours);
      mm = to_decimal(face.minutes);
      ss = to_decimal(face.seconds);
      // Blank-hours mode only hides the hours and the first colon.
      add_group(bdlr_pkg::SLOT_HOUR_TENS, hh / 10, face.blank_hours);
      add_group(bdlr_pkg::SLOT_HOUR_ONES, hh % 10, face.blank_hours);
      add_group(bdlr_pkg::SLOT_COLON_HM,  0,       face.blank_hours);
      add_group(bdlr_pkg::SLOT_MIN_TENS,  mm / 10, 1'b0);
      add_group(bdlr_pkg::SLOT_MIN_ONES,  mm % 10, 1'b0);
      add_group(bdlr_pkg::SLOT_COLON_MS,  0,       1'b0);
      add_group(bdlr_pkg::SLOT_SEC_TENS,  ss / 10, 1'b0);
      add_group(bdlr_pkg::SLOT_SEC_ONES,  ss % 10, 1'b0);
      expected_pairs[expected_pairs.size() - 1].last_write = 1'b1;
      frames_noted++;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t ns] MISMATCH %s", $time, what);
    endtask

    task check_pair(lcd_pair_t got);
      lcd_pair_t want;
      pairs_checked++;
      if (expected_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pair: addr %02h glyph %02h last %0b",
                                  got.cursor_address, got.glyph_code, got.last_write));
        return;
      end
      want = expected_pairs.pop_front();
      if (got.cursor_address !== want.cursor_address || got.glyph_code !== want.glyph_code ||
          got.last_write !== want.last_write) begin
        report_mismatch($sformatf(
          "pair %0d: got addr %02h glyph %02h last %0b, want addr %02h glyph %02h last %0b",
          pairs_checked - 1, got.cursor_address, got.glyph_code, got.last_write,
          want.cursor_address, want.glyph_code, want.last_write));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // Held high while the receiver refuses every pair for a long stretch.
  logic hold_off;

  frame_scoreboard frame_sb;

  bdlr_in_if  in_if ();
  bdlr_out_if out_if ();

  big_digit_lcd_renderer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on simulated time in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("big_digit_lcd_renderer verification failed");
    $finish;
  end

  // Receiver side: every pair taken at a clock edge is checked, then ready is
  // chosen for the next cycle from the current stall rate and the hold-off.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      frame_sb.check_pair('{out_if.cursor_address, out_if.glyph_code, out_if.last_write});
    end
    out_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Keeps the receiver off for a fixed number of cycles; runs as its own process
  // so the sender can keep offering frames until the block pushes back.
  task automatic hold_receiver(int unsigned cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // Offers one frame and returns at the edge where it is accepted. Valid is
  // written at most once per edge, so back-to-back frames keep it high.
  task automatic send_frame(clock_face_t face);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.blank_hours <= face.blank_hours;
    in_if.hours       <= face.hours;
    in_if.minutes     <= face.minutes;
    in_if.seconds     <= face.seconds;
    do @(posedge clk); while (!in_if.ready);
    frame_sb.note_frame(face);
  endtask

  // Stops offering and waits until every expected pair has come out. At least
  // one edge passes, so valid is never lowered and raised in the same step.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (frame_sb.expected_pairs.size() != 0);
  endtask

  // Mostly in-range values, sometimes anything the 7-bit field can hold.
  function automatic logic [bdlr_pkg::VALUE_W-1:0] random_value();
    if ($urandom_range(0, 7) == 0) begin
      return bdlr_pkg::VALUE_W'($urandom_range(0, 127));
    end
    return bdlr_pkg::VALUE_W'($urandom_range(0, 99));
  endfunction

  initial begin
    clock_face_t frames[$];
    clock_face_t face;
    int unsigned directed_count;
    int unsigned idle_start;
    int unsigned stall_start;
    int unsigned mixed_start;

    frame_sb          = new();
    rst_n             = 1'b0;
    hold_off          = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    in_if.valid       = 1'b0;
    in_if.blank_hours = 1'b0;
    in_if.hours       = '0;
    in_if.minutes     = '0;
    in_if.seconds     = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames: all zeros, the top of the range, values above 99 (the
    // all-ones field among them), blank-hours mode, and every digit in every
    // position of the display except 7 in the hours, whose frame is blanked.
    frames.push_back('{1'b0, 7'd0,   7'd0,   7'd0});
    frames.push_back('{1'b0, 7'd99,  7'd99,  7'd99});
    frames.push_back('{1'b0, 7'd100, 7'd100, 7'd100});
    frames.push_back('{1'b0, 7'd127, 7'd127, 7'd127});
    frames.push_back('{1'b1, 7'd12,  7'd34,  7'd56});
    frames.push_back('{1'b1, 7'd127, 7'd0,   7'd99});
    for (int unsigned d = 0; d < 10; d++) begin
      face.blank_hours = (d == 7);
      face.hours       = bdlr_pkg::VALUE_W'(11 * d);
      face.minutes     = bdlr_pkg::VALUE_W'(11 * (9 - d));
      face.seconds     = bdlr_pkg::VALUE_W'(10 * d + (d + 5) % 10);
      frames.push_back(face);
    end
    directed_count = frames.size();

    for (int unsigned k = 0; k < RANDOM_FRAMES; k++) begin
      face.blank_hours = 1'($urandom_range(0, 1));
      face.hours       = random_value();
      face.minutes     = random_value();
      face.seconds     = random_value();
      frames.push_back(face);
    end

    // Idling phases: none, sender idle, receiver stalling, then both.
    idle_start  = directed_count + 90;
    stall_start = directed_count + 170;
    mixed_start = directed_count + 250;

    for (int unsigned k = 0; k < frames.size(); k++) begin
      if (k == idle_start || k == stall_start || k == mixed_start) begin
        // The sender pauses at each phase change until the display is caught up.
        wait_drained();
        send_idle_pct  = (k == stall_start) ? 0 : ((k == mixed_start) ? 19 : 47);
        recv_stall_pct = (k == idle_start) ? 0 : ((k == mixed_start) ? 19 : 47);
      end
      if (k == directed_count + 40) begin
        // Receiver goes deaf while frames keep coming, so the queue fills up.
        fork
          hold_receiver(HOLD_CYCLES);
        join_none
      end
      send_frame(frames[k]);
    end

    wait_drained();
    // Anything the block still emits now is reported as unexpected.
    repeat (50) @(posedge clk);

    $display("Run covered %0d frames and %0d pairs: directed edge values, blank-hours mode,",
             frame_sb.frames_noted, frame_sb.pairs_checked);
    $display("clamped values, idle and stall phases, and a long output hold-off.");
    if (frame_sb.mismatches == 0 && frame_sb.expected_pairs.size() == 0) begin
      $display("big_digit_lcd_renderer verification clean");
    end else begin
      $display("%0d mismatches, %0d pairs still expected", frame_sb.mismatches,
               frame_sb.expected_pairs.size());
      $display("big_digit_lcd_renderer verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/bdlr_pkg.sv
sv/bdlr_if.sv
sv/bdlr_front.sv
sv/bdlr_queue.sv
sv/bdlr_back.sv
sv/big_digit_lcd_renderer.sv
dv/big_digit_lcd_renderer_test.sv
